FILE: sv/lfsd_pkg.sv
package lfsd_pkg;

  // Field widths fixed by the item formats.
  localparam int TIME_W  = 48;
  localparam int COUNT_W = 32;
  localparam int IDX_W   = 4;
  localparam int CFG_W   = 5;

  // Saturation limits.
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register map and reset value.
  localparam logic REG_SERVERS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] SERVERS_RESET = 5'd16;

  // One job request.
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } in_item_t;

  // One dispatch result.
  typedef struct packed {
    logic [IDX_W-1:0]   server_index;
    logic [TIME_W-1:0]  actual_start;
    logic [TIME_W-1:0]  actual_end;
    logic               was_delayed;
    logic [IDX_W-1:0]   busiest_server;
    logic [COUNT_W-1:0] busiest_count;
  } out_item_t;

endpackage

FILE: sv/lowest_free_server_dispatcher_core.sv
// Pipeline: a job accepted at a clock edge is captured in the input register; its
// selection and state update then feed the result register, which drives out_strobe.
// Throughput: one job per cycle; busy stays low, since each job's server choice and
// release update fit between the input and result registers.
// Reset (rst_n low, synchronous) frees all servers, clears job counts and the busiest
// tracking, and sets servers_in_use to 16. The receiver cannot stall results.
module lowest_free_server_dispatcher_core #(
  parameter int MAX_SERVERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lfsd_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output lfsd_pkg::out_item_t  out_item,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int SEL_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  logic [lfsd_pkg::CFG_W-1:0]   servers_r;
  logic                         v1_r;
  logic [lfsd_pkg::TIME_W-1:0]  start1_r;
  logic [lfsd_pkg::TIME_W-1:0]  dur1_r;
  logic [lfsd_pkg::TIME_W-1:0]  dur_nxt;
  logic [lfsd_pkg::TIME_W-1:0]  rel_r [MAX_SERVERS];
  logic [lfsd_pkg::COUNT_W-1:0] cnt_r [MAX_SERVERS];
  logic [SEL_W-1:0]             best_server_r;
  logic [SEL_W-1:0]             best_server_nxt;
  logic [lfsd_pkg::COUNT_W-1:0] best_count_r;
  logic [lfsd_pkg::COUNT_W-1:0] best_count_nxt;
  logic                         out_valid_r;
  lfsd_pkg::out_item_t          out_item_r;
  lfsd_pkg::out_item_t          out_item_nxt;
  logic [SEL_W-1:0]             pick;
  logic                         delayed;
  logic [lfsd_pkg::TIME_W-1:0]  act_start;
  logic [lfsd_pkg::TIME_W:0]    end_sum;
  logic [lfsd_pkg::TIME_W-1:0]  act_end;
  logic [lfsd_pkg::COUNT_W-1:0] cnt_old;
  logic [lfsd_pkg::COUNT_W-1:0] cnt_new;
  logic [SEL_W+lfsd_pkg::IDX_W-1:0] pick_wide;
  logic [SEL_W+lfsd_pkg::IDX_W-1:0] best_wide;
  logic                         cfg_wr;
  logic                         accept;

  // Configuration port: one register, writes complete in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == lfsd_pkg::REG_SERVERS_IN_USE) begin
      cfg_prdata = 32'(servers_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servers_r <= lfsd_pkg::SERVERS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == lfsd_pkg::REG_SERVERS_IN_USE)) begin
      servers_r <= cfg_pwdata[lfsd_pkg::CFG_W-1:0];
    end
  end

  // Input register: the job duration is formed on the way in.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign dur_nxt = (in_item.end_time > in_item.start_time) ?
                   (in_item.end_time - in_item.start_time) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start1_r <= in_item.start_time;
      dur1_r   <= dur_nxt;
    end
  end

  // Server choice against the current release times.
  lfsd_select #(
    .MAX_SERVERS (MAX_SERVERS),
    .SEL_W       (SEL_W)
  ) u_select (
    .rel_time       (rel_r),
    .start_time     (start1_r),
    .servers_in_use (servers_r),
    .pick           (pick),
    .delayed        (delayed)
  );

  // Actual times, with the end saturating at the top of the time range.
  assign act_start = delayed ? rel_r[pick] : start1_r;
  assign end_sum   = {1'b0, act_start} + {1'b0, dur1_r};
  assign act_end   = end_sum[lfsd_pkg::TIME_W] ? lfsd_pkg::TIME_MAX :
                     end_sum[lfsd_pkg::TIME_W-1:0];

  // Job count and busiest-server tracking.
  assign cnt_old = cnt_r[pick];
  assign cnt_new = (cnt_old == lfsd_pkg::COUNT_MAX) ? cnt_old : cnt_old + 1'b1;

  always_comb begin
    best_server_nxt = best_server_r;
    best_count_nxt  = best_count_r;
    if ((cnt_new > best_count_r) || ((cnt_new == best_count_r) && (pick < best_server_r))) begin
      best_server_nxt = pick;
      best_count_nxt  = cnt_new;
    end
  end

  assign pick_wide = (SEL_W + lfsd_pkg::IDX_W)'(pick);
  assign best_wide = (SEL_W + lfsd_pkg::IDX_W)'(best_server_nxt);

  always_comb begin
    out_item_nxt.server_index   = pick_wide[lfsd_pkg::IDX_W-1:0];
    out_item_nxt.actual_start   = act_start;
    out_item_nxt.actual_end     = act_end;
    out_item_nxt.was_delayed    = delayed;
    out_item_nxt.busiest_server = best_wide[lfsd_pkg::IDX_W-1:0];
    out_item_nxt.busiest_count  = best_count_nxt;
  end

  // Per-server state update for each job in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        rel_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      best_server_r <= '0;
      best_count_r  <= '0;
    end else if (v1_r) begin
      rel_r[pick]   <= act_end;
      cnt_r[pick]   <= cnt_new;
      best_server_r <= best_server_nxt;
      best_count_r  <= best_count_nxt;
    end
  end

  // Result register: each result is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

endmodule

FILE: sv/lfsd_select.sv
// Picks the server for one job: the lowest-numbered free server, or when none
// is free the server with the earliest release time, lowest index on ties.
module lfsd_select #(
  parameter int MAX_SERVERS = 16,
  parameter int SEL_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
  input  logic [lfsd_pkg::TIME_W-1:0] rel_time [MAX_SERVERS],
  input  logic [lfsd_pkg::TIME_W-1:0] start_time,
  input  logic [lfsd_pkg::CFG_W-1:0]  servers_in_use,
  output logic [SEL_W-1:0]            pick,
  output logic                        delayed
);

  logic [MAX_SERVERS-1:0] active;
  logic [MAX_SERVERS-1:0] free;
  logic [MAX_SERVERS-1:0] win;
  logic [MAX_SERVERS-1:0] lt [MAX_SERVERS];
  logic [SEL_W-1:0]       free_idx;
  logic [SEL_W-1:0]       win_idx;

  // Server 0 is always in use; the register value above the array size saturates.
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      active[i] = (i == 0) || (int'(servers_in_use) > i);
      free[i]   = active[i] && (rel_time[i] <= start_time);
    end
  end

  // All pairwise release-time compares in parallel.
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      for (int j = 0; j < MAX_SERVERS; j++) begin
        lt[i][j] = rel_time[i] < rel_time[j];
      end
    end
  end

  // A server holds the earliest release when it beats every lower active index
  // strictly and is not beaten by any higher one.
  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      win[i] = active[i];
      for (int j = 0; j < MAX_SERVERS; j++) begin
        if (active[j] && (j < i) && !lt[i][j]) begin
          win[i] = 1'b0;
        end
        if (active[j] && (j > i) && lt[j][i]) begin
          win[i] = 1'b0;
        end
      end
    end
  end

  // Lowest free index, and the index of the single earliest-release winner.
  always_comb begin
    free_idx = '0;
    win_idx  = '0;
    for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
      if (free[i]) begin
        free_idx = SEL_W'(i);
      end
      if (win[i]) begin
        win_idx = SEL_W'(i);
      end
    end
  end

  assign delayed = ~|free;
  assign pick    = delayed ? win_idx : free_idx;

endmodule
